FILE: src/tsph_pkg.sv
// ----------------------------------------------------------------------------
// tsph_pkg: shared types and constants for the track strip hit test
// Holds item structs, command codes and controller command/status types.
// ----------------------------------------------------------------------------
package tsph_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int HW_BITS        = 10;
  localparam int CNT_BITS       = 9;
  localparam int TRI_BITS       = 9;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLOSED_LOOP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               command;
    logic [7:0]         point_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] perp_x;
    logic signed [15:0] perp_y;
  } in_item_t;

  typedef struct packed {
    logic       is_query_reply;
    logic       found;
    logic [8:0] triangle_index;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch input item
    logic ofs_calc;  // register offsets
    logic write;     // write corner entry
    logic rd_start;  // read segment endpoints
    logic tri_sel;   // 0 even triangle, 1 odd triangle
    logic sub_calc;  // register differences
    logic mul_calc;  // register products
    logic sgn_calc;  // register sign flags
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic hit;
  } dp_stat_t;

endpackage

FILE: src/tsph_datapath.sv
// ----------------------------------------------------------------------------
// tsph_datapath: corner store, corner arithmetic and same-side test
// Computes corners on load; evaluates one triangle per test pass on query.
// ----------------------------------------------------------------------------
module tsph_datapath
  import tsph_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                clk,
  input  in_item_t            in_item,
  input  logic [HW_BITS-1:0]  half_width,
  input  logic [AW-1:0]       rd_a,
  input  logic [AW-1:0]       rd_b,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat
);

  localparam int CB = COORD_BITS;
  // Differences must hold both stored corners and full 16-bit query points
  localparam int DB = ((CB > 16) ? CB : 16) + 1;
  localparam int PB = 2 * DB;
  localparam int OB = 16 + HW_BITS + 1;

  typedef struct packed {
    logic signed [CB-1:0] lx;
    logic signed [CB-1:0] ly;
    logic signed [CB-1:0] rx;
    logic signed [CB-1:0] ry;
  } corner_t;

  corner_t mem [MAX_POINTS];
  corner_t ea, eb;
  in_item_t item;
  logic signed [OB-1:0] ofs_x, ofs_y;
  logic signed [DB-1:0] d [6];
  logic signed [PB-1:0] pr [6];
  logic n1, n2, n3;

  function automatic logic signed [OB-1:0] q14(input logic signed [OB-1:0] p);
    logic signed [OB-1:0] t;
    begin
      t = p + OB'(8192);
      q14 = t >>> 14;
    end
  endfunction

  function automatic logic signed [CB-1:0] sat(input logic signed [OB+1:0] v);
    logic signed [OB+1:0] hi, lo;
    begin
      hi = (OB+2)'((64'sd1 <<< (CB - 1)) - 1);
      lo = -hi - (OB+2)'(1);
      if (v > hi) sat = hi[CB-1:0];
      else if (v < lo) sat = lo[CB-1:0];
      else sat = v[CB-1:0];
    end
  endfunction

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_item;
  end

  // Offsets along the perpendicular
  always_ff @(posedge clk) begin
    if (cmd.ofs_calc) begin
      ofs_x <= q14(OB'(signed'({1'b0, half_width})) * OB'(item.perp_x));
      ofs_y <= q14(OB'(signed'({1'b0, half_width})) * OB'(item.perp_y));
    end
  end

  // Corner write and endpoint reads
  logic signed [OB+1:0] px_w, py_w;
  assign px_w = (OB+2)'(item.pos_x);
  assign py_w = (OB+2)'(item.pos_y);

  always_ff @(posedge clk) begin
    if (cmd.write && (MAX_POINTS >= 256 || 32'(item.point_index) < MAX_POINTS)) begin
      mem[AW'(item.point_index)] <= '{
        lx: sat(px_w + (OB+2)'(ofs_x)), ly: sat(py_w + (OB+2)'(ofs_y)),
        rx: sat(px_w - (OB+2)'(ofs_x)), ry: sat(py_w - (OB+2)'(ofs_y))};
    end
    if (cmd.rd_start) begin
      ea <= mem[rd_a];
      eb <= mem[rd_b];
    end
  end

  // Triangle vertices: even (La,Ra,Lb), odd (Rb,Ra,Lb)
  logic signed [DB-1:0] ax, ay, bx, by, cx, cy, qx, qy;
  always_comb begin
    ax = cmd.tri_sel ? DB'(eb.rx) : DB'(ea.lx);
    ay = cmd.tri_sel ? DB'(eb.ry) : DB'(ea.ly);
    bx = DB'(ea.rx);  by = DB'(ea.ry);
    cx = DB'(eb.lx);  cy = DB'(eb.ly);
    qx = DB'(item.pos_x); qy = DB'(item.pos_y);
  end

  // Differences, products, signs: one stage each
  always_ff @(posedge clk) begin
    if (cmd.sub_calc) begin
      d[0] <= qx - bx; d[1] <= ay - by;
      d[2] <= qx - cx; d[3] <= by - cy;
      d[4] <= qx - ax; d[5] <= cy - ay;
      pr[0] <= PB'(ax - bx); pr[1] <= PB'(qy - by);
      pr[2] <= PB'(bx - cx); pr[3] <= PB'(qy - cy);
      pr[4] <= PB'(cx - ax); pr[5] <= PB'(qy - ay);
    end
  end

  logic signed [PB-1:0] m [6];
  always_ff @(posedge clk) begin
    if (cmd.mul_calc) begin
      m[0] <= PB'(d[0]) * PB'(d[1]);
      m[1] <= pr[0] * pr[1];
      m[2] <= PB'(d[2]) * PB'(d[3]);
      m[3] <= pr[2] * pr[3];
      m[4] <= PB'(d[4]) * PB'(d[5]);
      m[5] <= pr[4] * pr[5];
    end
  end

  logic signed [PB:0] s1, s2, s3;
  assign s1 = (PB+1)'(m[0]) - (PB+1)'(m[1]);
  assign s2 = (PB+1)'(m[2]) - (PB+1)'(m[3]);
  assign s3 = (PB+1)'(m[4]) - (PB+1)'(m[5]);

  always_ff @(posedge clk) begin
    if (cmd.sgn_calc) begin
      n1 <= s1[PB]; n2 <= s2[PB]; n3 <= s3[PB];
    end
  end

  assign stat.is_query = item.command;
  assign stat.hit      = (n1 == n2) && (n2 == n3);

endmodule

FILE: src/tsph_ctrl.sv
// ----------------------------------------------------------------------------
// tsph_ctrl: sequencer for loads and triangle walk
// Steps load items through offset and write; walks segments on a query.
// ----------------------------------------------------------------------------
module tsph_ctrl
  import tsph_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                closed_loop,
  input  logic [CNT_BITS-1:0] point_count,
  output logic [AW-1:0]       rd_a,
  output logic [AW-1:0]       rd_b,
  output dp_cmd_t             cmd,
  input  dp_stat_t            stat
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_READ  = 9'b000001000,
    S_SUB   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_SGN   = 9'b001000000,
    S_CHK   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam int SB = $clog2(MAX_POINTS + 1);

  state_t state, state_next;
  logic [SB-1:0] seg, segs;
  logic tri_odd;
  logic [SB-1:0] n;

  // Clamp count and derive segment total
  always_comb begin
    n = (32'(point_count) > MAX_POINTS) ? SB'(MAX_POINTS) : SB'(point_count);
    if (closed_loop) segs = n;
    else segs = (n != '0) ? n - SB'(1) : '0;
  end

  assign rd_a = seg[AW-1:0];
  assign rd_b = (seg + SB'(1) < n) ? AW'(seg + SB'(1)) : '0;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.capture  = in_valid && in_ready;
    cmd.ofs_calc = (state == S_DEC);
    cmd.write    = (state == S_WRITE);
    cmd.rd_start = (state == S_READ);
    cmd.tri_sel  = tri_odd;
    cmd.sub_calc = (state == S_SUB);
    cmd.mul_calc = (state == S_MUL);
    cmd.sgn_calc = (state == S_SGN);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && in_ready) state_next = S_DEC;
      S_DEC:   state_next = stat.is_query ? ((segs == '0) ? S_DONE : S_READ) : S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_READ:  state_next = S_SUB;
      S_SUB:   state_next = S_MUL;
      S_MUL:   state_next = S_SGN;
      S_SGN:   state_next = S_CHK;
      S_CHK: begin
        if (stat.hit) state_next = S_DONE;
        else if (!tri_odd) state_next = S_SUB;
        else if (seg + SB'(1) < segs) state_next = S_READ;
        else state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      seg <= '0;
      tri_odd <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          seg <= '0;
          tri_odd <= 1'b0;
          // Hold a waiting result; clear only when the next item is taken
          if (in_valid && in_ready) out_item <= '0;
        end
        S_CHK: begin
          if (stat.hit) begin
            out_item.found <= 1'b1;
            out_item.triangle_index <= TRI_BITS'({seg, tri_odd});
          end else if (!tri_odd) begin
            tri_odd <= 1'b1;
          end else begin
            tri_odd <= 1'b0;
            seg <= seg + SB'(1);
          end
        end
        S_DONE: begin
          out_item.is_query_reply <= stat.is_query;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/track_strip_point_hit_test.sv
// ----------------------------------------------------------------------------
// track_strip_point_hit_test: triangle strip hit test along a centerline
// Loads edge corners and reports the first strip triangle holding a point.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready with an in_item_t payload. A load
// item stores the left and right corners of one centerline slot and returns
// one acknowledge; a query item returns the first containing triangle.
// Results leave on out_valid/out_ready as out_item_t, one per item.
// Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// Sequence: a load passes offset, corner write and result states. A query
// walks the segments; the even triangle of a segment takes corner read,
// subtract, multiply, sign and check, and the odd one, which reuses the
// corners, skips the read. One triangle is tested at a time through
// the sign pipeline. One item is worked at a time.
// Reset clears control state and configuration registers; the corner store is undefined
// until loaded. A stalled receiver holds the result; the next item is taken
// as soon as the result register is free or being emptied.
// ----------------------------------------------------------------------------
module track_strip_point_hit_test
  import tsph_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_item,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);

  logic [HW_BITS-1:0]  half_width;
  logic                closed_loop;
  logic [CNT_BITS-1:0] point_count;
  logic [AW-1:0] rd_a, rd_b;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= '0;
      closed_loop <= 1'b0;
      point_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_WIDTH:  half_width <= cfg_data[HW_BITS-1:0];
        REG_CLOSED_LOOP: closed_loop <= cfg_data[0];
        REG_POINT_COUNT: point_count <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  tsph_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .closed_loop(closed_loop), .point_count(point_count),
    .rd_a(rd_a), .rd_b(rd_b), .cmd(cmd), .stat(stat)
  );

  tsph_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .AW(AW)) u_dp (
    .clk(clk), .in_item(in_item), .half_width(half_width),
    .rd_a(rd_a), .rd_b(rd_b), .cmd(cmd), .stat(stat)
  );

endmodule

FILE: test/track_strip_point_hit_test_tb.sv
// ----------------------------------------------------------------------------
// track_strip_point_hit_test_tb: self-checking bench for the strip hit test
// Loads corner slots and queries points against a built-in predictor. The
// sender works in random bursts, the receiver stalls on its own pattern, and
// the strip settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module track_strip_point_hit_test_tb;
  import tsph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_item;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  track_strip_point_hit_test dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: corner slots and strip settings
  int unsigned       strip_half_width = 0;
  bit                strip_closed = 1'b0;
  int unsigned       strip_count = 0;
  longint            corner_lx[MAX_POINTS_DEF];
  longint            corner_ly[MAX_POINTS_DEF];
  longint            corner_rx[MAX_POINTS_DEF];
  longint            corner_ry[MAX_POINTS_DEF];

  in_item_t          pending_items[$];
  out_item_t         expected_replies[$];
  int                error_count = 0;
  int                gap_left = 0;
  int                burst_left = 0;
  int                gap_max = 0;
  int                stall_pct = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  // Append an item to the send queue
  function automatic void enqueue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint scale_q14(longint perp);
    longint prod;
    prod = longint'(strip_half_width) * perp + 8192;
    return prod >>> 14;
  endfunction

  function automatic longint side_sign(longint px, longint py, longint ax, longint ay,
                                       longint bx, longint by);
    return (px - bx) * (ay - by) - (ax - bx) * (py - by);
  endfunction

  function automatic bit in_triangle(longint px, longint py, longint ax, longint ay,
                                     longint bx, longint by, longint cx, longint cy);
    bit n1, n2, n3;
    n1 = side_sign(px, py, ax, ay, bx, by) < 0;
    n2 = side_sign(px, py, bx, by, cx, cy) < 0;
    n3 = side_sign(px, py, cx, cy, ax, ay) < 0;
    return (n1 == n2) && (n2 == n3);
  endfunction

  // Update corners on a load, walk the strip on a query
  function automatic out_item_t predict_reply(in_item_t it);
    out_item_t   r;
    longint      ox, oy, px, py;
    int unsigned n, segs, j;
    r = '0;
    px = it.pos_x;
    py = it.pos_y;
    if (it.command == CMD_LOAD) begin
      ox = scale_q14(it.perp_x);
      oy = scale_q14(it.perp_y);
      corner_lx[it.point_index] = sat_coord(px + ox);
      corner_ly[it.point_index] = sat_coord(py + oy);
      corner_rx[it.point_index] = sat_coord(px - ox);
      corner_ry[it.point_index] = sat_coord(py - oy);
      return r;
    end
    r.is_query_reply = 1'b1;
    n = (strip_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : strip_count;
    segs = strip_closed ? n : ((n > 0) ? n - 1 : 0);
    for (int unsigned i = 0; i < segs; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      if (in_triangle(px, py, corner_lx[i], corner_ly[i], corner_rx[i], corner_ry[i],
                      corner_lx[j], corner_ly[j])) begin
        r.found = 1'b1;
        r.triangle_index = 9'(2 * i);
        return r;
      end
      if (in_triangle(px, py, corner_rx[j], corner_ry[j], corner_rx[i], corner_ry[i],
                      corner_lx[j], corner_ly[j])) begin
        r.found = 1'b1;
        r.triangle_index = 9'(2 * i + 1);
        return r;
      end
    end
    return r;
  endfunction

  // Drive items in bursts; predict each accepted item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies.insert(expected_replies.size(), predict_reply(in_item));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Check each accepted reply against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", 1, 0);
        end else begin
          want = expected_replies.pop_front();
          if (out_item.is_query_reply !== want.is_query_reply)
            report_mismatch("is_query_reply", out_item.is_query_reply, want.is_query_reply);
          if (out_item.found !== want.found)
            report_mismatch("found", out_item.found, want.found);
          if (out_item.triangle_index !== want.triangle_index)
            report_mismatch("triangle_index", out_item.triangle_index, want.triangle_index);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    case (idx)
      REG_HALF_WIDTH:  strip_half_width = value & 10'h3FF;
      REG_CLOSED_LOOP: strip_closed = value[0];
      default:         strip_count = value & 9'h1FF;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_item_t load_item(int idx, int x, int y, int ppx, int ppy);
    in_item_t it;
    it.command = CMD_LOAD;
    it.point_index = 8'(idx);
    it.pos_x = 16'(sat_coord(x));
    it.pos_y = 16'(sat_coord(y));
    it.perp_x = 16'(ppx);
    it.perp_y = 16'(ppy);
    return it;
  endfunction

  function automatic in_item_t query_item(int x, int y);
    in_item_t it;
    it = load_item($urandom_range(0, 255), x, y, $urandom_range(0, 32768) - 16384,
                   $urandom_range(0, 32768) - 16384);
    it.command = CMD_QUERY;
    return it;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  initial begin
    int cx, cy, dx, dy, ppx, ppy, n, k, sent, nq;
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      corner_lx[i] = 0; corner_ly[i] = 0; corner_rx[i] = 0; corner_ry[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill every slot once so no query reads an unwritten corner
    write_reg(REG_HALF_WIDTH, 0);
    for (int i = 0; i < MAX_POINTS_DEF; i++)
      enqueue_item(load_item(i, rand_coord(), rand_coord(), 0, 0));
    wait_idle();

    // Directed: saturated corners, extreme fields, degenerate strips
    write_reg(REG_HALF_WIDTH, 1023);
    write_reg(REG_CLOSED_LOOP, 0);
    write_reg(REG_POINT_COUNT, 0);
    enqueue_item(load_item(0, 32767, 32767, 16384, 16384));
    enqueue_item(load_item(1, -32768, -32768, -16384, -16384));
    enqueue_item(load_item(2, 32767, -32768, 16384, -16384));
    enqueue_item(load_item(255, 0, 0, -16384, 16384));
    enqueue_item(query_item(0, 0));
    wait_idle();
    write_reg(REG_POINT_COUNT, 1);
    enqueue_item(query_item(32767, 32767));
    wait_idle();
    write_reg(REG_CLOSED_LOOP, 1);
    enqueue_item(query_item(32767, 32767));
    enqueue_item(query_item(-32768, 0));
    wait_idle();
    write_reg(REG_POINT_COUNT, 3);
    enqueue_item(query_item(0, 0));
    enqueue_item(query_item(32767, -32768));
    enqueue_item(query_item(-32768, -32768));
    enqueue_item(load_item(3, 100, 100, 8192, -8192));
    wait_idle();
    write_reg(REG_POINT_COUNT, 511);
    enqueue_item(query_item(0, 0));
    enqueue_item(query_item(32767, 0));
    wait_idle();

    // Random phases: well-formed strips with queries mostly near the centerline
    sent = 0;
    while (sent < 470) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_HALF_WIDTH, 1023);
        1: write_reg(REG_HALF_WIDTH, $urandom_range(0, 8));
        default: write_reg(REG_HALF_WIDTH, $urandom_range(0, 1023));
      endcase
      write_reg(REG_CLOSED_LOOP, $urandom_range(0, 1));
      n = ($urandom_range(0, 19) == 0) ? 256 : $urandom_range(0, 12);
      if ($urandom_range(0, 29) == 0) n = $urandom_range(257, 511);
      write_reg(REG_POINT_COUNT, n);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      cx = $urandom_range(0, 40000) - 20000;
      cy = $urandom_range(0, 40000) - 20000;
      dx = $urandom_range(0, 800) - 400;
      dy = $urandom_range(0, 800) - 400;
      if ($urandom_range(0, 1)) begin
        ppx = 0; ppy = 16384;
      end else begin
        ppx = 11585; ppy = -11585;
      end
      if ($urandom_range(0, 1)) begin
        ppx = -ppx; ppy = -ppy;
      end
      // Rebuild the strip (only slots in use, at most the small ones)
      for (int i = 0; i < ((n > 16) ? 16 : n); i++) begin
        enqueue_item(load_item(i, cx + i * dx + $urandom_range(0, 20) - 10,
                               cy + i * dy + $urandom_range(0, 20) - 10, ppx, ppy));
        sent++;
      end
      nq = (n > 16) ? 6 : $urandom_range(20, 50);
      for (int q = 0; q < nq; q++) begin
        k = $urandom_range(0, (n > 16) ? 15 : ((n > 0) ? n - 1 : 0));
        case ($urandom_range(0, 9))
          0: enqueue_item(query_item(rand_coord(), rand_coord()));
          1: enqueue_item(load_item($urandom_range(0, 255), rand_coord(),
                                    rand_coord(),
                                    $urandom_range(0, 32768) - 16384,
                                    $urandom_range(0, 32768) - 16384));
          default: enqueue_item(query_item(
                     cx + k * dx + int'($urandom_range(0, 2 * strip_half_width + 40))
                       - int'(strip_half_width) - 20,
                     cy + k * dy + int'($urandom_range(0, 2 * strip_half_width + 40))
                       - int'(strip_half_width) - 20));
        endcase
        sent++;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
